// File: hdl/lfu_pkg.sv
// Shared constants and types for the LFU slot replacement block.
// Used by the scan controller and the top level; depends on nothing.
`timescale 1ns / 1ps

package lfu_pkg;

  // Table size and id width.
  localparam int MAX_SLOTS = 16;
  localparam int ID_BITS   = 10;

  // Field widths fixed by the interface.
  localparam int CFG_BITS      = 5;
  localparam int COUNT_BITS    = 16;
  localparam int STAMP_BITS    = 32;
  localparam int OUT_SLOT_BITS = 4;

  // Widths derived from the table size.
  localparam int SLOT_BITS = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int LIM_BITS  = $clog2(MAX_SLOTS + 1);
  localparam int WIDE_BITS = (LIM_BITS > CFG_BITS) ? LIM_BITS : CFG_BITS;

  // Saturation limits.
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;

  // One table entry as stored in the memory.
  typedef struct packed {
    logic [ID_BITS-1:0]    id;
    logic [COUNT_BITS-1:0] count;
    logic [STAMP_BITS-1:0] stamp;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

  // Memory request from the controller to the entry RAM.
  typedef struct packed {
    logic                 rd_en;
    logic [SLOT_BITS-1:0] rd_addr;
    logic                 wr_en;
    logic [SLOT_BITS-1:0] wr_addr;
    entry_t               wr_data;
  } mem_req_t;

  // Controller states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_COMMIT = 4'b1000
  } state_t;

endpackage

// File: hdl/lfu_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered; no package dependency.
`timescale 1ns / 1ps

module lfu_ram #(
  parameter int WIDTH     = 8,
  parameter int DEPTH     = 16,
  parameter int ADDR_BITS = 4
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [WIDTH-1:0]     wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/lfu_ctrl.sv
// Scan controller: walks the entry RAM one slot per cycle, finds a hit, a free
// slot and the least-count oldest victim, then writes back. Uses lfu_pkg.
`timescale 1ns / 1ps

module lfu_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [lfu_pkg::ID_BITS-1:0]       item_id,
  input  logic [lfu_pkg::LIM_BITS-1:0]      limit,
  output logic                              busy,
  output lfu_pkg::mem_req_t                 mem_req,
  input  lfu_pkg::entry_t                   rd_entry,
  output logic                              done,
  output logic                              was_hit,
  output logic [lfu_pkg::OUT_SLOT_BITS-1:0] slot_index,
  output logic [lfu_pkg::COUNT_BITS-1:0]    count_now,
  output logic                              evicted_valid,
  output logic [lfu_pkg::ID_BITS-1:0]       evicted_id
);

  lfu_pkg::state_t state;
  lfu_pkg::state_t state_next;

  logic [lfu_pkg::LIM_BITS-1:0]   issue_cnt;
  logic [lfu_pkg::LIM_BITS-1:0]   lim_q;
  logic [lfu_pkg::ID_BITS-1:0]    id_q;
  logic                           pv;
  logic [lfu_pkg::SLOT_BITS-1:0]  pslot;
  logic                           hit;
  logic [lfu_pkg::SLOT_BITS-1:0]  hit_slot;
  logic [lfu_pkg::COUNT_BITS-1:0] hit_count;
  logic                           have_free;
  logic [lfu_pkg::SLOT_BITS-1:0]  free_slot;
  logic [lfu_pkg::SLOT_BITS-1:0]  best_slot;
  logic [lfu_pkg::COUNT_BITS-1:0] best_count;
  logic [lfu_pkg::STAMP_BITS-1:0] best_stamp;
  logic [lfu_pkg::ID_BITS-1:0]    best_id;
  logic [lfu_pkg::STAMP_BITS-1:0] item_clock;
  logic [lfu_pkg::MAX_SLOTS-1:0]  used_q;

  logic                           accept;
  logic                           last_issue;
  logic                           better;
  logic [lfu_pkg::SLOT_BITS-1:0]  commit_slot;
  logic [lfu_pkg::COUNT_BITS-1:0] commit_count;

  assign busy       = (state != lfu_pkg::ST_IDLE);
  assign accept     = start && !busy;
  assign last_issue = (issue_cnt == lim_q - lfu_pkg::LIM_BITS'(1));

  // Victim order: smaller count wins, then smaller stamp, then lower slot.
  assign better = (rd_entry.count < best_count) ||
                  ((rd_entry.count == best_count) && (rd_entry.stamp < best_stamp));

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      lfu_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = lfu_pkg::ST_SCAN;
        end
      end
      lfu_pkg::ST_SCAN: begin
        if (last_issue) begin
          state_next = lfu_pkg::ST_DRAIN;
        end
      end
      lfu_pkg::ST_DRAIN:  state_next = lfu_pkg::ST_COMMIT;
      lfu_pkg::ST_COMMIT: state_next = lfu_pkg::ST_IDLE;
      default:            state_next = lfu_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lfu_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Slot chosen at commit and its new count.
  always_comb begin
    if (hit) begin
      commit_slot  = hit_slot;
      commit_count = (hit_count == lfu_pkg::COUNT_MAX) ? hit_count
                                                       : hit_count + 1'b1;
    end else if (have_free) begin
      commit_slot  = free_slot;
      commit_count = lfu_pkg::COUNT_BITS'(1);
    end else begin
      commit_slot  = best_slot;
      commit_count = lfu_pkg::COUNT_BITS'(1);
    end
  end

  // Memory requests: reads during the scan, one write at commit.
  always_comb begin
    mem_req.rd_en         = (state == lfu_pkg::ST_SCAN);
    mem_req.rd_addr       = issue_cnt[lfu_pkg::SLOT_BITS-1:0];
    mem_req.wr_en         = (state == lfu_pkg::ST_COMMIT);
    mem_req.wr_addr       = commit_slot;
    mem_req.wr_data.id    = hit ? id_q : id_q;
    mem_req.wr_data.count = commit_count;
    mem_req.wr_data.stamp = hit ? best_stamp : item_clock;
    if (hit) begin
      // A hit keeps id and stamp; only the count changes, so rewrite the
      // stored stamp captured during the scan.
      mem_req.wr_data.stamp = best_stamp;
    end
  end

  // Read issue counter and return tag.
  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else begin
      pv <= (state == lfu_pkg::ST_SCAN);
    end
    pslot <= issue_cnt[lfu_pkg::SLOT_BITS-1:0];
    if (accept) begin
      issue_cnt <= '0;
      lim_q     <= limit;
      id_q      <= item_id;
    end else if (state == lfu_pkg::ST_SCAN) begin
      issue_cnt <= issue_cnt + 1'b1;
    end
  end

  // Scan results, one returned entry per cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      hit       <= 1'b0;
      have_free <= 1'b0;
    end else if (pv) begin
      if (used_q[pslot]) begin
        if (!hit && (rd_entry.id == id_q)) begin
          hit       <= 1'b1;
          hit_slot  <= pslot;
          hit_count <= rd_entry.count;
        end
      end else if (!have_free) begin
        have_free <= 1'b1;
        free_slot <= pslot;
      end
    end
  end

  // Victim tracking; the hit slot's stamp is kept here too for write-back.
  always_ff @(posedge clk) begin
    if (pv) begin
      if (used_q[pslot] && !hit && (rd_entry.id == id_q)) begin
        best_stamp <= rd_entry.stamp;
      end else if (!hit && ((pslot == '0) || better)) begin
        best_slot  <= pslot;
        best_count <= rd_entry.count;
        best_stamp <= rd_entry.stamp;
        best_id    <= rd_entry.id;
      end
    end
  end

  // Used bits and stamp clock.
  always_ff @(posedge clk) begin
    if (rst) begin
      used_q     <= '0;
      item_clock <= '0;
    end else if (state == lfu_pkg::ST_COMMIT) begin
      if (!hit) begin
        used_q[commit_slot] <= 1'b1;
      end
      if (item_clock != lfu_pkg::STAMP_MAX) begin
        item_clock <= item_clock + 1'b1;
      end
    end
  end

  // Result register, shown for one cycle after commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == lfu_pkg::ST_COMMIT);
    end
    if (state == lfu_pkg::ST_COMMIT) begin
      was_hit       <= hit;
      slot_index    <= lfu_pkg::OUT_SLOT_BITS'(commit_slot);
      count_now     <= commit_count;
      evicted_valid <= !hit && !have_free;
      evicted_id    <= (!hit && !have_free) ? best_id : '0;
    end
  end

`ifndef SYNTHESIS
  a_done_after_commit: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == lfu_pkg::ST_COMMIT))
    else $error("result strobe without a commit");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("request accepted but controller not busy");

  a_evict_not_hit: assert property (@(posedge clk) disable iff (rst)
    (done && evicted_valid) |-> !was_hit)
    else $error("eviction reported on a hit");

  a_evict_id_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !evicted_valid) |-> (evicted_id == '0))
    else $error("evicted id nonzero without eviction");
`endif

endmodule

// File: hdl/lfu_slot_replacement.sv
// Top level of the LFU slot replacement block: limit register, entry RAM and
// scan controller. Uses lfu_pkg, lfu_ram and lfu_ctrl.
`timescale 1ns / 1ps

// Usage
// A request is taken at a rising edge where start is high and busy is low;
// item_id is sampled then. The block looks the id up in its slot table and
// answers with one result: was_hit, slot_index, count_now, evicted_valid and
// evicted_id, shown for exactly one cycle while done is high.
// The entry RAM is read one slot per cycle over the active limit, then the
// controller drains the last read and commits the write-back, and a new
// request can be taken in the cycle where done is shown.
// The user must write the limit register (slots_in_use_we / slots_in_use)
// only while idle; the block does not enforce this. Zero acts as one slot
// and values above the table size act as the full table.
// Reset clears the used bits, the stamp clock and the controller, and sets
// the limit to the full table; no clearing pass is needed.
// The receiver cannot stall: each result is taken in the cycle it is shown.

module lfu_slot_replacement (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [lfu_pkg::ID_BITS-1:0]       item_id,
  input  logic                              slots_in_use_we,
  input  logic [lfu_pkg::CFG_BITS-1:0]      slots_in_use,
  output logic                              done,
  output logic                              was_hit,
  output logic [lfu_pkg::OUT_SLOT_BITS-1:0] slot_index,
  output logic [lfu_pkg::COUNT_BITS-1:0]    count_now,
  output logic                              evicted_valid,
  output logic [lfu_pkg::ID_BITS-1:0]       evicted_id
);

  logic [lfu_pkg::CFG_BITS-1:0]  limit_reg;
  logic [lfu_pkg::WIDE_BITS-1:0] limit_wide;
  logic [lfu_pkg::LIM_BITS-1:0]  limit;
  lfu_pkg::mem_req_t             mem_req;
  lfu_pkg::entry_t               rd_entry;
  logic [lfu_pkg::ENTRY_BITS-1:0] rd_data;

  // Limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      limit_reg <= lfu_pkg::CFG_BITS'(lfu_pkg::MAX_SLOTS);
    end else if (slots_in_use_we) begin
      limit_reg <= slots_in_use;
    end
  end

  // Clamp the limit into one to the table size.
  always_comb begin
    limit_wide = lfu_pkg::WIDE_BITS'(limit_reg);
    if (limit_wide == '0) begin
      limit_wide = lfu_pkg::WIDE_BITS'(1);
    end else if (limit_wide > lfu_pkg::WIDE_BITS'(lfu_pkg::MAX_SLOTS)) begin
      limit_wide = lfu_pkg::WIDE_BITS'(lfu_pkg::MAX_SLOTS);
    end
    limit = lfu_pkg::LIM_BITS'(limit_wide);
  end

  assign rd_entry = lfu_pkg::entry_t'(rd_data);

  lfu_ram #(
    .WIDTH    (lfu_pkg::ENTRY_BITS),
    .DEPTH    (lfu_pkg::MAX_SLOTS),
    .ADDR_BITS(lfu_pkg::SLOT_BITS)
  ) u_ram (
    .clk    (clk),
    .wr_en  (mem_req.wr_en),
    .wr_addr(mem_req.wr_addr),
    .wr_data(mem_req.wr_data),
    .rd_en  (mem_req.rd_en),
    .rd_addr(mem_req.rd_addr),
    .rd_data(rd_data)
  );

  lfu_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .item_id      (item_id),
    .limit        (limit),
    .busy         (busy),
    .mem_req      (mem_req),
    .rd_entry     (rd_entry),
    .done         (done),
    .was_hit      (was_hit),
    .slot_index   (slot_index),
    .count_now    (count_now),
    .evicted_valid(evicted_valid),
    .evicted_id   (evicted_id)
  );

endmodule

// File: tb/lfu_checker.sv
// Checker for the LFU slot replacement block: keeps its own slot table,
// predicts each lookup and compares every result. Depends on lfu_pkg.
`timescale 1ns / 1ps

module lfu_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              busy,
  input  logic [lfu_pkg::ID_BITS-1:0]       item_id,
  input  logic                              slots_in_use_we,
  input  logic [lfu_pkg::CFG_BITS-1:0]      slots_in_use,
  input  logic                              done,
  input  logic                              was_hit,
  input  logic [lfu_pkg::OUT_SLOT_BITS-1:0] slot_index,
  input  logic [lfu_pkg::COUNT_BITS-1:0]    count_now,
  input  logic                              evicted_valid,
  input  logic [lfu_pkg::ID_BITS-1:0]       evicted_id,
  output int                                n_fail,
  output int                                n_pending
);

  // One predicted lookup result.
  typedef struct packed {
    logic                              hit;
    logic [lfu_pkg::OUT_SLOT_BITS-1:0] slot;
    logic [lfu_pkg::COUNT_BITS-1:0]    count;
    logic                              ev_valid;
    logic [lfu_pkg::ID_BITS-1:0]       ev_id;
  } lookup_t;

  // Shadow copy of the slot table and the limit register.
  logic [lfu_pkg::ID_BITS-1:0]    tbl_id    [lfu_pkg::MAX_SLOTS];
  logic [lfu_pkg::COUNT_BITS-1:0] tbl_count [lfu_pkg::MAX_SLOTS];
  logic [lfu_pkg::STAMP_BITS-1:0] tbl_stamp [lfu_pkg::MAX_SLOTS];
  logic                           tbl_used  [lfu_pkg::MAX_SLOTS];
  logic [lfu_pkg::STAMP_BITS-1:0] stamp_clock;
  logic [lfu_pkg::CFG_BITS-1:0]   limit_reg;

  lookup_t expected_lookups[$];

  // Looks one id up in the shadow table, updates the table and returns the
  // result the block should show.
  function automatic lookup_t predict_lookup(input logic [lfu_pkg::ID_BITS-1:0] id);
    lookup_t r;
    int      lim;
    int      slot;
    int      free_slot;
    bit      hit;
    bit      have_free;
    lim       = int'(limit_reg);
    slot      = 0;
    free_slot = 0;
    hit       = 1'b0;
    have_free = 1'b0;
    r         = '0;
    if (lim < 1) lim = 1;
    if (lim > lfu_pkg::MAX_SLOTS) lim = lfu_pkg::MAX_SLOTS;

    // Only slots below the active limit take part in the search.
    for (int s = 0; s < lim; s++) begin
      if (tbl_used[s]) begin
        if (!hit && tbl_id[s] == id) begin
          hit  = 1'b1;
          slot = s;
        end
      end else if (!have_free) begin
        have_free = 1'b1;
        free_slot = s;
      end
    end

    if (hit) begin
      r.hit = 1'b1;
      if (tbl_count[slot] < lfu_pkg::COUNT_MAX)
        tbl_count[slot] = tbl_count[slot] + 1'b1;
    end else begin
      if (have_free) begin
        slot = free_slot;
      end else begin
        // Table full: least count wins, then the oldest stamp, then the lowest slot.
        slot = 0;
        for (int s = 1; s < lim; s++) begin
          if (tbl_count[s] < tbl_count[slot] ||
              (tbl_count[s] == tbl_count[slot] && tbl_stamp[s] < tbl_stamp[slot]))
            slot = s;
        end
        r.ev_valid = 1'b1;
        r.ev_id    = tbl_id[slot];
      end
      tbl_id[slot]    = id;
      tbl_count[slot] = lfu_pkg::COUNT_BITS'(1);
      tbl_stamp[slot] = stamp_clock;
      tbl_used[slot]  = 1'b1;
    end

    r.slot  = slot[lfu_pkg::OUT_SLOT_BITS-1:0];
    r.count = tbl_count[slot];
    if (stamp_clock < lfu_pkg::STAMP_MAX) stamp_clock = stamp_clock + 1'b1;
    return r;
  endfunction

  // Results are compared before a request taken at the same edge is predicted.
  always @(posedge clk) begin
    lookup_t want;
    if (rst) begin
      for (int s = 0; s < lfu_pkg::MAX_SLOTS; s++) tbl_used[s] = 1'b0;
      stamp_clock = '0;
      limit_reg   = lfu_pkg::CFG_BITS'(lfu_pkg::MAX_SLOTS);
      expected_lookups.delete();
    end else begin
      if (done) begin
        if (expected_lookups.size() == 0) begin
          n_fail++;
          $error("result shown with no request outstanding");
        end else begin
          want = expected_lookups.pop_front();
          if (was_hit !== want.hit) begin
            n_fail++;
            $error("was_hit: expected %0d, actual %0d", want.hit, was_hit);
          end
          if (slot_index !== want.slot) begin
            n_fail++;
            $error("slot_index: expected %0d, actual %0d", want.slot, slot_index);
          end
          if (count_now !== want.count) begin
            n_fail++;
            $error("count_now: expected %0d, actual %0d", want.count, count_now);
          end
          if (evicted_valid !== want.ev_valid) begin
            n_fail++;
            $error("evicted_valid: expected %0d, actual %0d", want.ev_valid,
                   evicted_valid);
          end
          if (evicted_id !== want.ev_id) begin
            n_fail++;
            $error("evicted_id: expected %0d, actual %0d", want.ev_id, evicted_id);
          end
        end
      end
      if (slots_in_use_we) limit_reg = slots_in_use;
      if (start && !busy) expected_lookups = {expected_lookups, predict_lookup(item_id)};
    end
    n_pending = expected_lookups.size();
  end

endmodule

// File: tb/tb_lfu_slot_replacement.sv
// Testbench top for the LFU slot replacement block: drives requests and limit
// writes, and gives the verdict. Depends on lfu_pkg, lfu_checker and the block.
`timescale 1ns / 1ps

module tb_lfu_slot_replacement;

  localparam int SETTLE      = lfu_pkg::MAX_SLOTS + 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 57;
  localparam int REPEAT_HITS = 20;

  logic                              clk             = 1'b0;
  logic                              rst             = 1'b1;
  logic                              start           = 1'b0;
  logic [lfu_pkg::ID_BITS-1:0]       item_id         = '0;
  logic                              slots_in_use_we = 1'b0;
  logic [lfu_pkg::CFG_BITS-1:0]      slots_in_use    = '0;
  logic                              busy;
  logic                              done;
  logic                              was_hit;
  logic [lfu_pkg::OUT_SLOT_BITS-1:0] slot_index;
  logic [lfu_pkg::COUNT_BITS-1:0]    count_now;
  logic                              evicted_valid;
  logic [lfu_pkg::ID_BITS-1:0]       evicted_id;
  int                                n_fail;
  int                                n_pending;
  int                                cycle_count = 0;
  bit                                allow_idle  = 1'b1;

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lfu_slot_replacement DUT (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .item_id         (item_id),
    .slots_in_use_we (slots_in_use_we),
    .slots_in_use    (slots_in_use),
    .done            (done),
    .was_hit         (was_hit),
    .slot_index      (slot_index),
    .count_now       (count_now),
    .evicted_valid   (evicted_valid),
    .evicted_id      (evicted_id)
  );

  lfu_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .item_id         (item_id),
    .slots_in_use_we (slots_in_use_we),
    .slots_in_use    (slots_in_use),
    .done            (done),
    .was_hit         (was_hit),
    .slot_index      (slot_index),
    .count_now       (count_now),
    .evicted_valid   (evicted_valid),
    .evicted_id      (evicted_id),
    .n_fail          (n_fail),
    .n_pending       (n_pending)
  );

  // Presents one request, sometimes after a random gap, and returns at the
  // edge where it is taken. Start stays high for a following request.
  task automatic issue(input logic [lfu_pkg::ID_BITS-1:0] id);
    int gap;
    gap = 0;
    if (allow_idle && $urandom_range(99) < 25) gap = $urandom_range(SETTLE, 1);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    item_id <= id;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Waits until every request has been answered and the block is quiet.
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (n_pending != 0 || busy);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes the limit register while the block is idle.
  task automatic set_limit(input logic [lfu_pkg::CFG_BITS-1:0] value);
    drain();
    slots_in_use_we <= 1'b1;
    slots_in_use    <= value;
    @(posedge clk);
    slots_in_use_we <= 1'b0;
  endtask

  // Run limit.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_lfu_slot_replacement: errors");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    logic [lfu_pkg::CFG_BITS-1:0] phase_limits[9];
    logic [lfu_pkg::ID_BITS-1:0]  hot_ids[$];
    logic [lfu_pkg::CFG_BITS-1:0] lim_val;
    logic [lfu_pkg::ID_BITS-1:0]  id;
    int                           eff;
    int                           keep;
    int                           pick;

    phase_limits = '{5'd16, 5'd4, 5'd1, 5'd0, 5'd31, 5'd8, 5'd17, 5'd2, 5'd0};

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: fill at the reset limit, extreme ids, then hits.
    issue('0);
    issue('1);
    issue(lfu_pkg::ID_BITS'(10'h155));
    issue(lfu_pkg::ID_BITS'(10'h2AA));
    issue('0);
    issue('0);
    issue('1);

    // Two slots: the least count is replaced for each new id, then id zero hits.
    set_limit(lfu_pkg::CFG_BITS'(2));
    issue(lfu_pkg::ID_BITS'(5));
    issue(lfu_pkg::ID_BITS'(6));
    issue('0);

    // Three slots: equal counts, so the older stamp is replaced.
    set_limit(lfu_pkg::CFG_BITS'(3));
    issue(lfu_pkg::ID_BITS'(7));
    issue(lfu_pkg::ID_BITS'(6));

    // A limit of zero acts as one slot; ids kept in higher slots must miss.
    set_limit('0);
    issue('0);
    issue(lfu_pkg::ID_BITS'(6));
    issue(lfu_pkg::ID_BITS'(7));

    // A limit above the table acts as the full table; leftovers hit again.
    set_limit('1);
    issue(lfu_pkg::ID_BITS'(10'h2AA));
    issue(lfu_pkg::ID_BITS'(6));
    issue('1);
    issue(lfu_pkg::ID_BITS'(10'h3C0));

    // One slot hit over and over back to back: the count keeps climbing.
    set_limit(lfu_pkg::CFG_BITS'(1));
    allow_idle = 1'b0;
    repeat (REPEAT_HITS) issue(lfu_pkg::ID_BITS'(10'h3C5));
    issue(lfu_pkg::ID_BITS'(10'h03A));
    allow_idle = 1'b1;

    // Random phases, each at its own limit, over a pool of hot ids that is
    // partly carried over so that ids left beyond a lowered limit come back.
    for (int p = 0; p < 9; p++) begin
      lim_val = (p == 8) ? lfu_pkg::CFG_BITS'($urandom_range(31)) : phase_limits[p];
      set_limit(lim_val);
      allow_idle = !(p == 4 || p == 5);
      eff = (lim_val == '0) ? 1 : int'(lim_val);
      if (eff > lfu_pkg::MAX_SLOTS) eff = lfu_pkg::MAX_SLOTS;
      keep = hot_ids.size() / 2;
      while (hot_ids.size() > keep) void'(hot_ids.pop_front());
      while (hot_ids.size() < eff + 3)
        hot_ids = {hot_ids, lfu_pkg::ID_BITS'($urandom_range(1023))};
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(99) < 75) begin
          if ($urandom_range(1) == 1) pick = $urandom_range(2);
          else pick = $urandom_range(hot_ids.size() - 1);
          id = hot_ids[pick];
        end else begin
          id = lfu_pkg::ID_BITS'($urandom_range(1023));
        end
        issue(id);
      end
    end

    drain();
    @(negedge clk);
    if (n_fail == 0 && n_pending == 0)
      $display("tb_lfu_slot_replacement: clean");
    else
      $display("tb_lfu_slot_replacement: errors");
    $finish;
  end

endmodule
